// ----- rtl/gtrr_pkg.sv -----
// ----------------------------------------------------------------------------
// gtrr_pkg
// Shared types, constants and the 5x7 font ROM of the glyph rectangle
// rasterizer.
// ----------------------------------------------------------------------------
package gtrr_pkg;

  localparam int COORD_W            = 18;
  localparam int CURSOR_W           = 16;
  localparam int MAX_RECTS          = 20;
  localparam int CNT_W              = 5;
  localparam int DEF_DISPLAY_WIDTH  = 800;
  localparam int DEF_DISPLAY_HEIGHT = 480;

  localparam logic signed [CURSOR_W:0] CURSOR_MAX = 17'sd32767;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5a;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  typedef enum logic [2:0] {SH_NONE, SH_GLYPH, SH_DASH, SH_SLASH, SH_COLON} shape_t;

  // five columns, bit 0 of each column is the top row
  typedef logic [0:4][6:0] glyph_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
    logic push;
    logic push_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lit;
    logic last_step;
    logic hold_valid;
    logic out_free;
  } ctrl_stat_t;

  function automatic shape_t shape_of(input logic [7:0] ch);
    shape_t sh;
    if ((ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_A && ch <= CH_Z)) sh = SH_GLYPH;
    else if (ch == CH_DASH) sh = SH_DASH;
    else if (ch == CH_SLASH) sh = SH_SLASH;
    else if (ch == CH_COLON) sh = SH_COLON;
    else sh = SH_NONE;
    return sh;
  endfunction

  function automatic logic [5:0] glyph_index(input logic [7:0] ch);
    logic [5:0] idx;
    if (ch <= CH_NINE) idx = 6'(ch - CH_ZERO);
    else idx = 6'(ch - CH_A + 8'd10);
    return idx;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [5:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
      6'd1:  g = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
      6'd2:  g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      6'd3:  g = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
      6'd4:  g = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
      6'd5:  g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      6'd6:  g = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
      6'd7:  g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      6'd8:  g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      6'd9:  g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
      6'd10: g = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
      6'd11: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
      6'd12: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
      6'd13: g = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
      6'd14: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
      6'd15: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
      6'd16: g = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
      6'd17: g = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
      6'd18: g = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
      6'd19: g = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
      6'd20: g = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
      6'd21: g = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
      6'd22: g = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
      6'd23: g = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
      6'd24: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
      6'd25: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
      6'd26: g = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
      6'd27: g = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
      6'd28: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      6'd29: g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
      6'd30: g = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
      6'd31: g = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
      6'd32: g = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
      6'd33: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      6'd34: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      6'd35: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_hi(
    input logic signed [COORD_W-1:0] v,
    input logic signed [COORD_W-1:0] hi
  );
    logic signed [COORD_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/gtrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtrr_ctrl
// Sequencer: accepts a character, walks the shape steps, hands found
// rectangles from the hold stage to the output stage and flushes the last.
// ----------------------------------------------------------------------------
module gtrr_ctrl
  import gtrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   advance;

  // a lit step needs the hold stage empty or draining this cycle
  assign advance = !stat.lit || !stat.hold_valid || stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (advance && stat.last_step) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat.hold_valid || stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SCAN: begin
        cmd.step    = advance;
        cmd.capture = stat.lit && advance;
        cmd.push    = stat.lit && advance && stat.hold_valid;
      end
      ST_FLUSH: begin
        cmd.push      = stat.hold_valid && stat.out_free;
        cmd.push_last = stat.hold_valid && stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_free)
    else $error("push while output stage is full");

  a_capture_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && stat.hold_valid) |-> cmd.push)
    else $error("hold stage overwritten");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && state_next == ST_IDLE && stat.hold_valid) |-> cmd.push_last)
    else $error("character ended without final rectangle");

endmodule

// ----- rtl/gtrr_datapath.sv -----
// ----------------------------------------------------------------------------
// gtrr_datapath
// Cursor, character registers, shape step counters, rectangle build and
// clip, hold stage and output stage.
// ----------------------------------------------------------------------------
module gtrr_datapath
  import gtrr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  input  logic [55:0] s_tdata,
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(DISPLAY_WIDTH);
  localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(DISPLAY_HEIGHT);

  logic signed [11:0] in_origin_x;
  logic signed [11:0] in_origin_y;
  logic [7:0]         in_char;
  logic [3:0]         in_scale;
  logic [15:0]        in_color;

  logic signed [CURSOR_W-1:0] cursor;
  logic signed [CURSOR_W-1:0] base_x;
  logic signed [CURSOR_W:0]   adv_sum;
  logic [6:0]                 adv;

  logic signed [COORD_W-1:0] xbase;
  logic signed [COORD_W-1:0] ybase;
  logic [3:0]                scale_r;
  logic [15:0]               color_r;
  shape_t                    shape_r;
  glyph_t                    glyph_r;
  logic [2:0]                col;
  logic [2:0]                row;
  logic [CNT_W-1:0]          count;

  logic [2:0] dx_u, dy_u, w_u, h_u;
  logic [6:0] px, py, pw, ph;
  logic signed [COORD_W-1:0] x0, y0, x1, y1;
  logic signed [COORD_W-1:0] cxs, cys, cxe, cye;
  logic                      vis;

  logic        hold_valid;
  logic [9:0]  h_xs, h_xe;
  logic [8:0]  h_ys, h_ye;
  logic        h_vis;

  logic [9:0]  o_xs, o_xe;
  logic [8:0]  o_ys, o_ye;
  logic [15:0] o_color;
  logic        shape_lit;
  logic        last_step;
  logic        out_free;

  assign in_origin_x = s_tdata[11:0];
  assign in_origin_y = s_tdata[23:12];
  assign in_char     = s_tdata[31:24];
  assign in_scale    = s_tdata[35:32];
  assign in_color    = s_tdata[51:36];

  assign base_x  = s_tuser ? CURSOR_W'(in_origin_x) : cursor;
  assign adv     = 7'({in_scale, 2'b00}) + 7'({in_scale, 1'b0});
  assign adv_sum = (CURSOR_W+1)'(base_x) + signed'((CURSOR_W+1)'(adv));

  // per-step offsets and size, in glyph pixels
  always_comb begin
    dx_u = '0;
    dy_u = '0;
    w_u  = 3'd1;
    h_u  = 3'd1;
    shape_lit = 1'b1;
    last_step = 1'b1;
    case (shape_r)
      SH_GLYPH: begin
        dx_u = col;
        dy_u = row;
        shape_lit = glyph_r[col][row];
        last_step = (col == 3'd4) && (row == 3'd6);
      end
      SH_DASH: begin
        dy_u = 3'd3;
        w_u  = 3'd5;
      end
      SH_SLASH: begin
        dx_u = col;
        dy_u = 3'd5 - col;
        last_step = (col == 3'd4);
      end
      SH_COLON: begin
        dx_u = 3'd2;
        dy_u = (col == 3'd0) ? 3'd1 : 3'd5;
        last_step = (col == 3'd1);
      end
      default: begin
        shape_lit = 1'b0;
      end
    endcase
  end

  assign px = 7'(dx_u) * 7'(scale_r);
  assign py = 7'(dy_u) * 7'(scale_r);
  assign pw = 7'(w_u) * 7'(scale_r);
  assign ph = 7'(h_u) * 7'(scale_r);

  assign x0 = xbase + signed'(COORD_W'(px));
  assign y0 = ybase + signed'(COORD_W'(py));
  assign x1 = x0 + signed'(COORD_W'(pw));
  assign y1 = y0 + signed'(COORD_W'(ph));

  assign cxs = clamp_hi(x0, X_LIM);
  assign cxe = clamp_hi(x1, X_LIM);
  assign cys = clamp_hi(y0, Y_LIM);
  assign cye = clamp_hi(y1, Y_LIM);
  assign vis = (cxs < cxe) && (cys < cye);

  assign out_free        = !m_tvalid || m_tready;
  assign stat.lit        = shape_lit && (count != CNT_W'(MAX_RECTS));
  assign stat.last_step  = last_step;
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      shape_r    <= SH_NONE;
      col        <= '0;
      row        <= '0;
      count      <= '0;
    end else begin
      if (cmd.load) begin
        cursor  <= (adv_sum > CURSOR_MAX) ? CURSOR_MAX[CURSOR_W-1:0] : adv_sum[CURSOR_W-1:0];
        shape_r <= shape_of(in_char);
        col     <= '0;
        row     <= '0;
        count   <= '0;
      end else if (cmd.step) begin
        if (shape_r == SH_GLYPH && row != 3'd6) begin
          row <= row + 3'd1;
        end else begin
          row <= '0;
          col <= col + 3'd1;
        end
      end
      if (cmd.capture) begin
        hold_valid <= 1'b1;
        count      <= count + CNT_W'(1);
      end else if (cmd.push) begin
        hold_valid <= 1'b0;
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xbase   <= COORD_W'(base_x);
      ybase   <= COORD_W'(in_origin_y);
      scale_r <= in_scale;
      color_r <= in_color;
      glyph_r <= glyph_lookup(glyph_index(in_char));
    end
    if (cmd.capture) begin
      h_vis <= vis;
      h_xs  <= vis ? cxs[9:0] : '0;
      h_xe  <= vis ? cxe[9:0] : '0;
      h_ys  <= vis ? cys[8:0] : '0;
      h_ye  <= vis ? cye[8:0] : '0;
    end
    if (cmd.push) begin
      o_xs    <= h_xs;
      o_xe    <= h_xe;
      o_ys    <= h_ys;
      o_ye    <= h_ye;
      o_color <= color_r;
      m_tuser <= h_vis;
      m_tlast <= cmd.push_last;
    end
  end

  assign m_tdata = {2'b00, o_color, o_ye, o_xe, o_ys, o_xs};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECTS))
    else $error("rectangle count overrun");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[37:0] == '0))
    else $error("hidden rectangle with nonzero bounds");

  a_push_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> m_tvalid)
    else $error("pushed rectangle not presented");

endmodule

// ----- rtl/glyph_text_rect_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// glyph_text_rect_rasterizer_top
// Turns a stream of characters into clipped fill rectangles.
// ----------------------------------------------------------------------------
// Input channel s_*: one character per item. tuser carries new_string, which
// reloads the cursor from origin_x before the character is drawn.
// Output channel m_*: one rectangle per item, tuser is the visible flag,
// tlast marks the final rectangle of a character. Characters without a
// shape produce no items but still advance the cursor by 6*scale.
// An item is loaded, scanned one step per glyph bit of the 5x7 scan for
// digits and letters, one step per rectangle for dash, slash and colon
// and a single step otherwise, and then flushed. The scan stalls on a lit
// bit while a rectangle waits in the hold stage and the output stage is
// full. A rectangle waits in the hold stage until the next lit bit or the
// flush moves it to the output stage.
// A stalled receiver backs up the scan; nothing is dropped. The next item is
// accepted while the last rectangle still waits in the output stage.
// Reset clears the cursor to 0 and empties both stages.
// ----------------------------------------------------------------------------
module glyph_text_rect_rasterizer_top
  import gtrr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // origin_x[11:0], origin_y[23:12], char_code[31:24], scale[35:32],
  // ink_color[51:36], zero pad[55:52]
  input  logic [55:0] s_tdata,
  // new_string
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // x_start[9:0], y_start[18:10], x_end[28:19], y_end[37:29],
  // fill_color[53:38], zero pad[55:54]
  output logic [55:0] m_tdata,
  // visible
  output logic        m_tuser,
  output logic        m_tlast
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  gtrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtrr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/glyph_text_rect_rasterizer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rect_rasterizer_checker
// Watches both stream channels of the glyph rectangle rasterizer. Each
// accepted character is turned into the rectangles it must produce, using a
// local font table, cursor and clipping. Each accepted rectangle is compared
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module glyph_text_rect_rasterizer_checker
  import gtrr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // origin_x[11:0], origin_y[23:12], char_code[31:24], scale[35:32],
  // ink_color[51:36], zero pad[55:52]
  input  logic [55:0] s_tdata,
  // new_string
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // x_start[9:0], y_start[18:10], x_end[28:19], y_end[37:29],
  // fill_color[53:38], zero pad[55:54]
  input  logic [55:0] m_tdata,
  // visible
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef logic [0:4][6:0] font_cols_t;

  typedef struct packed {
    logic [9:0]  xs;
    logic [8:0]  ys;
    logic [9:0]  xe;
    logic [8:0]  ye;
    logic [15:0] color;
    logic        vis;
    logic        last;
  } rect_t;

  rect_t rect_q[$];
  rect_t char_rects[MAX_RECTS];
  int    n_char_rects;
  int    cursor;
  int    rect_no;

  function automatic font_cols_t font_cols(input int idx);
    font_cols_t f;
    case (idx)
      0:  f = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
      1:  f = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
      2:  f = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      3:  f = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
      4:  f = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
      5:  f = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      6:  f = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
      7:  f = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      8:  f = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      9:  f = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
      10: f = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
      11: f = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
      12: f = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
      13: f = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
      14: f = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
      15: f = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
      16: f = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
      17: f = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
      18: f = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
      19: f = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
      20: f = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
      21: f = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
      22: f = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
      23: f = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
      24: f = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
      25: f = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
      26: f = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
      27: f = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
      28: f = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      29: f = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
      30: f = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
      31: f = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
      32: f = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
      33: f = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      34: f = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      35: f = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic int clip(input int v, input int hi);
    int r;
    if (v < 0) r = 0;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: rect %0d: %s", $realtime, rect_no, msg);
    errors++;
  endtask

  task automatic add_square(input int x, input int y, input int w, input int h,
                            input logic [15:0] color);
    int    xs, xe, ys, ye;
    rect_t r;
    xs = clip(x, DISPLAY_WIDTH);
    xe = clip(x + w, DISPLAY_WIDTH);
    ys = clip(y, DISPLAY_HEIGHT);
    ye = clip(y + h, DISPLAY_HEIGHT);
    r = '0;
    r.color = color;
    if (xs < xe && ys < ye) begin
      r.xs  = 10'(xs);
      r.ys  = 9'(ys);
      r.xe  = 10'(xe);
      r.ye  = 9'(ye);
      r.vis = 1'b1;
    end
    if (n_char_rects < MAX_RECTS) begin
      char_rects[n_char_rects] = r;
      n_char_rects++;
    end
  endtask

  task automatic predict_char(input logic ns, input logic [11:0] ox,
                              input logic [11:0] oy, input logic [7:0] ch,
                              input logic [3:0] sc, input logic [15:0] color);
    int         x, y, s, col, row, i;
    font_cols_t f;
    rect_t      r;
    if (ns) cursor = int'($signed(ox));
    y = int'($signed(oy));
    s = int'(sc);
    x = cursor;
    n_char_rects = 0;
    if ((ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_A && ch <= CH_Z)) begin
      if (ch <= CH_NINE) f = font_cols(int'(ch) - int'(CH_ZERO));
      else f = font_cols(int'(ch) - int'(CH_A) + 10);
      for (col = 0; col < 5; col++)
        for (row = 0; row < 7; row++)
          if (f[col][row]) add_square(x + col * s, y + row * s, s, s, color);
    end else if (ch == CH_DASH) begin
      add_square(x, y + 3 * s, 5 * s, s, color);
    end else if (ch == CH_SLASH) begin
      for (i = 0; i < 5; i++) add_square(x + i * s, y + (5 - i) * s, s, s, color);
    end else if (ch == CH_COLON) begin
      add_square(x + 2 * s, y + s, s, s, color);
      add_square(x + 2 * s, y + 5 * s, s, s, color);
    end
    for (i = 0; i < n_char_rects; i++) begin
      r = char_rects[i];
      r.last = (i == n_char_rects - 1);
      rect_q.push_back(r);
    end
    cursor = cursor + 6 * s;
    if (cursor > int'(CURSOR_MAX)) cursor = int'(CURSOR_MAX);
  endtask

  task automatic check_rect();
    rect_t e;
    if (rect_q.size() == 0) begin
      report("rectangle with none expected");
    end else begin
      e = rect_q.pop_front();
      if (m_tdata[9:0] !== e.xs)
        report($sformatf("x_start got %0d expected %0d", m_tdata[9:0], e.xs));
      if (m_tdata[18:10] !== e.ys)
        report($sformatf("y_start got %0d expected %0d", m_tdata[18:10], e.ys));
      if (m_tdata[28:19] !== e.xe)
        report($sformatf("x_end got %0d expected %0d", m_tdata[28:19], e.xe));
      if (m_tdata[37:29] !== e.ye)
        report($sformatf("y_end got %0d expected %0d", m_tdata[37:29], e.ye));
      if (m_tdata[53:38] !== e.color)
        report($sformatf("fill_color got %h expected %h", m_tdata[53:38], e.color));
      if (m_tdata[55:54] !== 2'b00)
        report($sformatf("pad bits got %b", m_tdata[55:54]));
      if (m_tuser !== e.vis)
        report($sformatf("visible got %b expected %b", m_tuser, e.vis));
      if (m_tlast !== e.last)
        report($sformatf("last_rect got %b expected %b", m_tlast, e.last));
    end
    rect_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cursor  = 0;
      errors  = 0;
      rect_no = 0;
      rect_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        predict_char(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[31:24],
                     s_tdata[35:32], s_tdata[51:36]);
      if (m_tvalid && m_tready) check_rect();
    end
    pending = rect_q.size();
  end

endmodule

// ----- tb/tb_glyph_text_rect_rasterizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_text_rect_rasterizer_top
// Drives characters into the glyph rectangle rasterizer: a directed set of
// shapes, codes and clipping corners, then random strings with a long run
// that pushes the cursor into saturation. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_glyph_text_rect_rasterizer_top;
  import gtrr_pkg::*;

  localparam int DISP_W       = DEF_DISPLAY_WIDTH;
  localparam int DISP_H       = DEF_DISPLAY_HEIGHT;
  localparam int RANDOM_ITEMS = 80;
  localparam int SAT_RUN      = 360;
  localparam int DRAIN_CYCLES = 64;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          errors;
  int          pending;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  int          sent     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_text_rect_rasterizer_top #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  glyph_text_rect_rasterizer_checker #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .errors  (errors),
    .pending (pending)
  );

  function automatic int pick_gap();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 55) g = 0;
    else if (r < 85) g = $urandom_range(1, 3);
    else if (r < 97) g = $urandom_range(4, 12);
    else g = $urandom_range(20, 60);
    return g;
  endfunction

  function automatic logic [7:0] rand_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 40) c = 8'(int'(CH_A) + $urandom_range(0, 25));
    else if (r < 60) c = 8'(int'(CH_ZERO) + $urandom_range(0, 9));
    else if (r < 67) c = CH_DASH;
    else if (r < 72) c = CH_SLASH;
    else if (r < 77) c = CH_COLON;
    else c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_char(input logic ns, input logic [11:0] ox, input logic [11:0] oy,
                           input logic [7:0] ch, input logic [3:0] sc,
                           input logic [15:0] color);
    int gap;
    s_tuser  = ns;
    s_tdata  = {4'h0, color, sc, ch, oy, ox};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic send_string();
    int          len, i;
    logic [11:0] ox, oy;
    logic [3:0]  sc;
    logic [15:0] color;
    len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
    if ($urandom_range(0, 99) < 75) begin
      ox = 12'($urandom_range(0, DISP_W - 1));
      oy = 12'($urandom_range(0, DISP_H - 1));
    end else begin
      ox = 12'($urandom);
      oy = 12'($urandom);
    end
    sc       = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom);
    color    = 16'($urandom);
    tx_quiet = ($urandom_range(0, 4) == 0);
    send_char(1'b1, ox, oy, rand_char(), sc, color);
    for (i = 1; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) sc = 4'($urandom);
      if ($urandom_range(0, 9) == 0) color = 16'($urandom);
      send_char($urandom_range(0, 19) == 0, 12'($urandom), oy, rand_char(), sc, color);
    end
  endtask

  // long string at the widest advance so the cursor pins at its maximum
  task automatic saturate_cursor();
    int          i;
    logic [15:0] color;
    color    = 16'($urandom);
    tx_quiet = 1'b0;
    send_char(1'b1, 12'd2047, 12'd20, "H", 4'd15, color);
    for (i = 0; i < SAT_RUN; i++)
      send_char(1'b0, 12'($urandom), 12'($urandom),
                ($urandom_range(0, 99) < 85) ? 8'h20 : rand_char(), 4'd15, color);
    send_char(1'b0, 12'd0, 12'd0, CH_DASH, 4'd15, color);
    send_char(1'b0, 12'd0, 12'd0, "8", 4'd0, color);
    send_char(1'b0, 12'd0, 12'd0, CH_COLON, 4'd1, color);
    send_char(1'b1, 12'd0, 12'd10, "E", 4'd1, color);
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) rx_quiet = ~rx_quiet;
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    int  base;
    logic sat_done;
    sat_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_char(1'b1, 12'd0, 12'd0, "0", 4'd1, 16'hffff);
    send_char(1'b0, 12'd0, 12'd0, "8", 4'd1, 16'h0000);
    send_char(1'b0, 12'd0, 12'd0, "W", 4'd8, 16'h1234);
    send_char(1'b0, 12'd0, 12'd0, CH_DASH, 4'd2, 16'h5aa5);
    send_char(1'b0, 12'd0, 12'd0, CH_SLASH, 4'd3, 16'ha55a);
    send_char(1'b0, 12'd0, 12'd0, CH_COLON, 4'd1, 16'h0f0f);
    send_char(1'b0, 12'd0, 12'd0, " ", 4'd4, 16'hf0f0);
    send_char(1'b0, 12'd0, 12'd0, 8'h00, 4'd1, 16'h0001);
    send_char(1'b0, 12'hfff, 12'hfff, 8'hff, 4'd15, 16'h8000);
    send_char(1'b1, 12'(-2048), 12'(-2048), "M", 4'd8, 16'hffff);
    send_char(1'b1, 12'd2047, 12'd2047, "A", 4'd1, 16'h0000);
    send_char(1'b1, 12'd795, 12'd476, "B", 4'd2, 16'h7e7e);
    send_char(1'b1, 12'(-5), 12'(-3), "Z", 4'd3, 16'h1111);
    send_char(1'b1, 12'd100, 12'd100, "5", 4'd0, 16'h2222);
    send_char(1'b0, 12'd0, 12'd100, CH_DASH, 4'd0, 16'h3333);
    send_char(1'b1, 12'd10, 12'd10, "Q", 4'd15, 16'h4444);
    send_char(1'b0, 12'd0, 12'd10, "z", 4'd1, 16'h5555);
    send_char(1'b0, 12'd0, 12'd10, "@", 4'd1, 16'h6666);
    send_char(1'b0, 12'd0, 12'd10, "[", 4'd1, 16'h7777);
    send_char(1'b0, 12'd0, 12'd10, ",", 4'd1, 16'h8888);
    send_char(1'b0, 12'd0, 12'd10, ".", 4'd1, 16'h9999);
    send_char(1'b0, 12'd0, 12'd10, "9", 4'd1, 16'haaaa);
    send_char(1'b1, 12'd792, 12'd470, CH_SLASH, 4'd4, 16'hbbbb);
    send_char(1'b1, 12'd0, 12'd0, "1", 4'd7, 16'hcccc);
    wait_idle();

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      send_string();
      if (!sat_done && sent - base >= RANDOM_ITEMS / 2) begin
        wait_idle();
        saturate_cursor();
        sat_done = 1'b1;
        base = base + (SAT_RUN + 5);
      end
      if ($urandom_range(0, 14) == 0) wait_idle();
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gtrr_pkg.sv
rtl/gtrr_ctrl.sv
rtl/gtrr_datapath.sv
rtl/glyph_text_rect_rasterizer_top.sv
tb/glyph_text_rect_rasterizer_checker.sv
tb/tb_glyph_text_rect_rasterizer_top.sv
